// ----- rtl/rau_pkg.sv -----
// Shared types and constants for the rational arithmetic unit.
`timescale 1ns / 1ps

package rau_pkg;

    localparam int OPERAND_WIDTH_DEF = 16;
    localparam int RES_NUM_W         = 32;
    localparam int RES_DEN_W         = 31;
    localparam int MODE_W            = 2;

    localparam logic [MODE_W-1:0] MODE_ADD = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SUB = 2'd1;
    localparam logic [MODE_W-1:0] MODE_MUL = 2'd2;
    localparam logic [MODE_W-1:0] MODE_DIV = 2'd3;

    localparam logic STATUS_OK      = 1'b0;
    localparam logic STATUS_DIVZERO = 1'b1;

    typedef enum logic {
        OP_GCD,
        OP_DIV
    } iter_op_t;

    typedef struct packed {
        logic     go;
        iter_op_t op;
    } iter_cmd_t;

endpackage

// ----- rtl/rau_mul.sv -----
// Registered signed multiplier shared by the operand cross products.
`timescale 1ns / 1ps

module rau_mul #(
    parameter int W = rau_pkg::OPERAND_WIDTH_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic signed [W-1:0]   a,
    input  logic signed [W-1:0]   b,
    output logic signed [2*W-1:0] p
);

    logic signed [2*W-1:0] p_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_reg <= '0;
        end
        else
        begin
            p_reg <= a * b;
        end
    end

    assign p = p_reg;

endmodule

// ----- rtl/rau_iter.sv -----
// Iterative binary GCD and restoring divider around one shared subtractor.
`timescale 1ns / 1ps

module rau_iter #(
    parameter int MW = 2 * rau_pkg::OPERAND_WIDTH_DEF - 1
) (
    input  logic               clk,
    input  logic               rst_n,
    input  rau_pkg::iter_cmd_t cmd,
    input  logic [MW-1:0]      opa,
    input  logic [MW-1:0]      opb,
    output logic               done,
    output logic [MW-1:0]      result
);

    localparam int SW = MW + 2;
    localparam int KW = $clog2(MW + 1);

    typedef enum logic [1:0] {
        I_IDLE,
        I_GCD,
        I_DIV
    } istate_t;

    istate_t       st_reg;
    logic [MW-1:0] x_reg;
    logic [MW-1:0] y_reg;
    logic [MW-1:0] r_reg;
    logic [KW-1:0] k_reg;
    logic [KW-1:0] cnt_reg;
    logic          done_reg;
    logic [MW-1:0] res_reg;

    logic [SW-1:0] lhs;
    logic [SW-1:0] rhs;
    logic [SW-1:0] diff;
    logic [SW-1:0] ndiff;
    logic          borrow;
    logic [MW-1:0] x_div_next;

    // shared subtractor: x - y for GCD, shifted remainder - divisor for division
    always_comb
    begin
        lhs = (st_reg == I_DIV) ? {1'b0, r_reg, x_reg[MW-1]} : {2'b00, x_reg};
        rhs = {2'b00, y_reg};
        diff = lhs - rhs;
        ndiff = '0 - diff;
        borrow = diff[SW-1];
        x_div_next = {x_reg[MW-2:0], ~borrow};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg   <= I_IDLE;
            x_reg    <= '0;
            y_reg    <= '0;
            r_reg    <= '0;
            k_reg    <= '0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
            res_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (st_reg)
                I_IDLE:
                begin
                    if (cmd.go)
                    begin
                        x_reg   <= opa;
                        y_reg   <= opb;
                        r_reg   <= '0;
                        k_reg   <= '0;
                        cnt_reg <= KW'(MW - 1);
                        st_reg  <= (cmd.op == rau_pkg::OP_GCD) ? I_GCD : I_DIV;
                    end
                end
                I_GCD:
                begin
                    if (x_reg == '0)
                    begin
                        res_reg  <= y_reg << k_reg;
                        done_reg <= 1'b1;
                        st_reg   <= I_IDLE;
                    end
                    else if (y_reg == '0)
                    begin
                        res_reg  <= x_reg << k_reg;
                        done_reg <= 1'b1;
                        st_reg   <= I_IDLE;
                    end
                    else if (!x_reg[0] && !y_reg[0])
                    begin
                        x_reg <= x_reg >> 1;
                        y_reg <= y_reg >> 1;
                        k_reg <= k_reg + 1'b1;
                    end
                    else if (!x_reg[0])
                    begin
                        x_reg <= x_reg >> 1;
                    end
                    else if (!y_reg[0])
                    begin
                        y_reg <= y_reg >> 1;
                    end
                    else if (!borrow)
                    begin
                        // odd minus odd is even: halve in the same step
                        x_reg <= diff[MW:1];
                    end
                    else
                    begin
                        y_reg <= ndiff[MW:1];
                    end
                end
                I_DIV:
                begin
                    r_reg <= borrow ? {r_reg[MW-2:0], x_reg[MW-1]} : diff[MW-1:0];
                    x_reg <= x_div_next;
                    if (cnt_reg == '0)
                    begin
                        res_reg  <= x_div_next;
                        done_reg <= 1'b1;
                        st_reg   <= I_IDLE;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg - 1'b1;
                    end
                end
                default:
                begin
                    st_reg <= I_IDLE;
                end
            endcase
        end
    end

    assign done   = done_reg;
    assign result = res_reg;

    a_go_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.go |-> st_reg == I_IDLE)
        else $error("iteration unit started while busy");

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("done held for more than one cycle");

    a_gcd_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        st_reg == I_GCD |-> (x_reg != '0 || y_reg != '0))
        else $error("gcd operands both zero");

endmodule

// ----- rtl/rational_arith_unit_core.sv -----
// Top level of the rational arithmetic unit: operand products, sign, reduction, result.
//
//  channel | dir | fields (tdata / tuser, lowest bit first)
//  s_axis  | in  | tdata: a_num, a_den, b_num, b_den, zero pad; tuser: mode
//  m_axis  | out | tdata: res_num, res_den, zero pad;          tuser: status
//
// One transaction at a time: s_axis_tready is high only while idle.
// Per item: cross products, then the binary GCD, then two divisions by the GCD,
// all on MW = 2*OPERAND_WIDTH-1 bit magnitudes.
// The binary GCD loop and the bit-serial divider share one subtractor.
// Bad operands or divide by zero go straight to the output with status set.
// Result waits in the output register until m_axis_tready; asynchronous reset.
`timescale 1ns / 1ps

module rational_arith_unit_core #(
    parameter int OPERAND_WIDTH = rau_pkg::OPERAND_WIDTH_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // a_num, a_den, b_num, b_den, zero pad
    input  logic [8*((4*OPERAND_WIDTH+5)/8)-1:0]  s_axis_tdata,
    // mode
    input  logic [rau_pkg::MODE_W-1:0]            s_axis_tuser,
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // res_num, res_den, zero pad
    output logic [8*((rau_pkg::RES_NUM_W+rau_pkg::RES_DEN_W+7)/8)-1:0] m_axis_tdata,
    // status
    output logic                                  m_axis_tuser
);

    localparam int W   = OPERAND_WIDTH;
    localparam int PW  = 2 * W;
    localparam int MW  = 2 * W - 1;
    localparam int NW  = rau_pkg::RES_NUM_W;
    localparam int DW  = rau_pkg::RES_DEN_W;
    localparam int ODW = 8 * ((NW + DW + 7) / 8);
    localparam int XW  = (MW + 1 > NW) ? MW + 1 : NW;
    localparam int YW  = (MW > DW) ? MW : DW;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MA,
        S_MB,
        S_MC,
        S_MD,
        S_PREP,
        S_GCD_GO,
        S_GCD_WAIT,
        S_DN_GO,
        S_DN_WAIT,
        S_DD_GO,
        S_DD_WAIT,
        S_OUT
    } state_t;

    state_t                     state_reg;
    logic [rau_pkg::MODE_W-1:0] mode_reg;
    logic signed [W-1:0]        an_reg;
    logic [W-2:0]               ad_reg;
    logic signed [W-1:0]        bn_reg;
    logic [W-2:0]               bd_reg;
    logic signed [PW-1:0]       n_reg;
    logic signed [PW-1:0]       d_reg;
    logic                       neg_reg;
    logic [MW-1:0]              mag_reg;
    logic [MW-1:0]              dm_reg;
    logic [MW-1:0]              g_reg;
    logic [MW-1:0]              qn_reg;
    logic [NW-1:0]              onum_reg;
    logic [DW-1:0]              oden_reg;
    logic                       ostat_reg;

    logic signed [W-1:0]   in_an;
    logic [W-2:0]          in_ad;
    logic signed [W-1:0]   in_bn;
    logic [W-2:0]          in_bd;
    logic                  in_bad;
    logic signed [W-1:0]   ad_ext;
    logic signed [W-1:0]   bd_ext;
    logic signed [W-1:0]   mul_a;
    logic signed [W-1:0]   mul_b;
    logic signed [PW-1:0]  prod;
    logic [PW-1:0]         n_abs;
    logic [PW-1:0]         d_abs;
    rau_pkg::iter_cmd_t    it_cmd;
    logic [MW-1:0]         it_opa;
    logic [MW-1:0]         it_opb;
    logic                  it_done;
    logic [MW-1:0]         it_res;
    logic [XW-1:0]         qn_ext;
    logic [XW-1:0]         num_full;
    logic [YW-1:0]         den_full;

    assign in_an = s_axis_tdata[W-1:0];
    assign in_ad = s_axis_tdata[2*W-2:W];
    assign in_bn = s_axis_tdata[3*W-2:2*W-1];
    assign in_bd = s_axis_tdata[4*W-3:3*W-1];

    assign in_bad = (in_ad == '0) || (in_bd == '0)
                    || (s_axis_tuser == rau_pkg::MODE_DIV && in_bn == '0);

    assign ad_ext = signed'({1'b0, ad_reg});
    assign bd_ext = signed'({1'b0, bd_reg});

    // cross products issued one per cycle: first, second, then ad*bd
    always_comb
    begin
        mul_a = an_reg;
        mul_b = bd_ext;
        case (state_reg)
            S_MA:
            begin
                if (mode_reg == rau_pkg::MODE_MUL)
                begin
                    mul_b = bn_reg;
                end
            end
            S_MB:
            begin
                if (mode_reg == rau_pkg::MODE_MUL)
                begin
                    mul_a = ad_ext;
                    mul_b = bd_ext;
                end
                else if (mode_reg == rau_pkg::MODE_DIV)
                begin
                    mul_a = ad_ext;
                    mul_b = bn_reg;
                end
                else
                begin
                    mul_a = bn_reg;
                    mul_b = ad_ext;
                end
            end
            S_MC:
            begin
                mul_a = ad_ext;
                mul_b = bd_ext;
            end
            default:
            begin
                mul_a = an_reg;
                mul_b = bd_ext;
            end
        endcase
    end

    rau_mul #(
        .W (W)
    ) u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .a     (mul_a),
        .b     (mul_b),
        .p     (prod)
    );

    always_comb
    begin
        it_cmd.go = 1'b0;
        it_cmd.op = rau_pkg::OP_DIV;
        it_opa    = mag_reg;
        it_opb    = g_reg;
        case (state_reg)
            S_GCD_GO:
            begin
                it_cmd.go = 1'b1;
                it_cmd.op = rau_pkg::OP_GCD;
                it_opb    = dm_reg;
            end
            S_DN_GO:
            begin
                it_cmd.go = 1'b1;
            end
            S_DD_GO:
            begin
                it_cmd.go = 1'b1;
                it_opa    = dm_reg;
            end
            default:
            begin
                it_cmd.go = 1'b0;
            end
        endcase
    end

    rau_iter #(
        .MW (MW)
    ) u_iter (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (it_cmd),
        .opa    (it_opa),
        .opb    (it_opb),
        .done   (it_done),
        .result (it_res)
    );

    assign n_abs    = n_reg[PW-1] ? PW'(-n_reg) : PW'(n_reg);
    assign d_abs    = d_reg[PW-1] ? PW'(-d_reg) : PW'(d_reg);
    assign qn_ext   = XW'(qn_reg);
    assign num_full = neg_reg ? (XW'(0) - qn_ext) : qn_ext;
    assign den_full = YW'(it_res);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            mode_reg  <= '0;
            an_reg    <= '0;
            ad_reg    <= '0;
            bn_reg    <= '0;
            bd_reg    <= '0;
            n_reg     <= '0;
            d_reg     <= '0;
            neg_reg   <= 1'b0;
            mag_reg   <= '0;
            dm_reg    <= '0;
            g_reg     <= '0;
            qn_reg    <= '0;
            onum_reg  <= '0;
            oden_reg  <= '0;
            ostat_reg <= rau_pkg::STATUS_OK;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (s_axis_tvalid)
                    begin
                        mode_reg <= s_axis_tuser;
                        an_reg   <= in_an;
                        ad_reg   <= in_ad;
                        bn_reg   <= in_bn;
                        bd_reg   <= in_bd;
                        if (in_bad)
                        begin
                            onum_reg  <= '0;
                            oden_reg  <= DW'(1);
                            ostat_reg <= rau_pkg::STATUS_DIVZERO;
                            state_reg <= S_OUT;
                        end
                        else
                        begin
                            state_reg <= S_MA;
                        end
                    end
                end
                S_MA:
                begin
                    state_reg <= S_MB;
                end
                S_MB:
                begin
                    n_reg     <= prod;
                    state_reg <= S_MC;
                end
                S_MC:
                begin
                    case (mode_reg)
                        rau_pkg::MODE_ADD: n_reg <= n_reg + prod;
                        rau_pkg::MODE_SUB: n_reg <= n_reg - prod;
                        default:           d_reg <= prod;
                    endcase
                    state_reg <= S_MD;
                end
                S_MD:
                begin
                    if (mode_reg == rau_pkg::MODE_ADD || mode_reg == rau_pkg::MODE_SUB)
                    begin
                        d_reg <= prod;
                    end
                    state_reg <= S_PREP;
                end
                S_PREP:
                begin
                    if (n_reg == '0)
                    begin
                        onum_reg  <= '0;
                        oden_reg  <= DW'(1);
                        ostat_reg <= rau_pkg::STATUS_OK;
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        neg_reg   <= n_reg[PW-1] ^ d_reg[PW-1];
                        mag_reg   <= n_abs[MW-1:0];
                        dm_reg    <= d_abs[MW-1:0];
                        state_reg <= S_GCD_GO;
                    end
                end
                S_GCD_GO:
                begin
                    state_reg <= S_GCD_WAIT;
                end
                S_GCD_WAIT:
                begin
                    if (it_done)
                    begin
                        g_reg     <= it_res;
                        state_reg <= S_DN_GO;
                    end
                end
                S_DN_GO:
                begin
                    state_reg <= S_DN_WAIT;
                end
                S_DN_WAIT:
                begin
                    if (it_done)
                    begin
                        qn_reg    <= it_res;
                        state_reg <= S_DD_GO;
                    end
                end
                S_DD_GO:
                begin
                    state_reg <= S_DD_WAIT;
                end
                S_DD_WAIT:
                begin
                    if (it_done)
                    begin
                        onum_reg  <= num_full[NW-1:0];
                        oden_reg  <= den_full[DW-1:0];
                        ostat_reg <= rau_pkg::STATUS_OK;
                        state_reg <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    if (m_axis_tready)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = (state_reg == S_OUT);
    assign m_axis_tdata  = ODW'({oden_reg, onum_reg});
    assign m_axis_tuser  = ostat_reg;

    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("input taken while a result is pending");

    a_err_result: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && ostat_reg == rau_pkg::STATUS_DIVZERO)
            |-> (onum_reg == '0 && oden_reg == DW'(1)))
        else $error("error result is not 0/1");

    a_zero_canon: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && onum_reg == '0) |-> oden_reg == DW'(1))
        else $error("zero result without unit denominator");

    a_gcd_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_GCD_WAIT && it_done) |=> g_reg != '0)
        else $error("gcd came back zero");

endmodule
